// File: rtl/core/vp3m_pkg.sv
// Shared types, constants and fixed-point helpers for the virtual point datapath.
package vp3m_pkg;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] long_x;
		logic signed [31:0] long_y;
		logic signed [31:0] long_z;
		logic signed [31:0] plane_x;
		logic signed [31:0] plane_y;
		logic signed [31:0] plane_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               degenerate;
	} out_item_t;

	typedef logic [2:0][31:0] v3_t;
	typedef logic [2:0][63:0] p3_t;

	typedef struct packed {
		v3_t         org;
		v3_t         ox;
		v3_t         oy;
		logic        neg;
		logic        degen;
		logic        ovf;
		logic [63:0] den;
		logic [95:0] rem;
		logic [31:0] q;
	} div_t;

	localparam logic [1:0] REG_WEIGHT_LONG   = 2'd0;
	localparam logic [1:0] REG_WEIGHT_PLANE  = 2'd1;
	localparam logic [1:0] REG_WEIGHT_NORMAL = 2'd2;

	localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
	localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

	function automatic logic [31:0] sat32(input logic signed [71:0] v);
		logic [31:0] r;
		if (v > S32_MAX) begin
			r = 32'h7fff_ffff;
		end else if (v < S32_MIN) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// floor(p / 2^16), saturated
	function automatic logic [31:0] qsat(input logic signed [63:0] p);
		logic signed [71:0] w;
		w = 72'(p);
		return sat32(w >>> 16);
	endfunction

endpackage

// File: rtl/core/vp3m_div_step.sv
// One restoring division step of the projection ratio, registered.
module vp3m_div_step import vp3m_pkg::*; #(
	parameter int BIT = 31
) (
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout
);

	logic [95:0] sh;
	div_t        nxt;

	always_comb begin
		sh  = 96'(din.den) << BIT;
		nxt = din;
		if (!din.degen && !din.ovf && (din.rem >= sh)) begin
			nxt.rem    = din.rem - sh;
			nxt.q[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// File: rtl/core/virtual_point_from_three_markers_top.sv
// Virtual point from three markers: Gram-Schmidt local frame, weighted offset.
//
// Input channel item_valid/item_stall/item carries origin, long-axis marker and
// plane-axis marker, all signed Q16.16. Output channel point_valid/point_stall/
// point returns one result per input item: the saturated virtual point and a
// degenerate flag set when the long axis has zero length.
// Weights are written through wr_en/wr_idx/wr_data (0 long, 1 plane, 2 normal);
// other indexes are ignored. Write them only while the pipeline is empty.
// One item is accepted per cycle while item_stall is low. The pipeline depth is
// set by the projection ratio, a 32-stage restoring divider producing one quotient
// bit per stage, plus ten arithmetic stages.
// Each stage advances when it is empty or the stage after it advances, so a
// stall at the output fills bubbles first and then holds item_stall high.
// Reset clears all valid bits and sets the three weights to zero.
module virtual_point_from_three_markers_top import vp3m_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        point_valid,
	input  logic        point_stall,
	output out_item_t   point,
	input  logic        wr_en,
	input  logic [1:0]  wr_idx,
	input  logic [31:0] wr_data
);

	localparam int NDIV = 32;
	localparam int NST  = NDIV + 10;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;
	logic [31:0]    wl_q, wp_q, wn_q;

	v3_t org_in, long_in, plane_in;

	v3_t         org_s1, ox_s1, oy_s1;
	v3_t         org_s2, ox_s2, oy_s2;
	p3_t         pxx_s2, pxy_s2;
	div_t        dv_s3;
	div_t        dvo [NDIV];
	v3_t         org_s4, ox_s4, oy_s4;
	logic [31:0] s_s4;
	logic        dg_s4;
	v3_t         org_s5, ox_s5, oy_s5;
	p3_t         sp_s5;
	logic        dg_s5;
	v3_t         org_s6, ox_s6, oy_s6;
	logic        dg_s6;
	v3_t         org_s7, ox_s7, oy_s7;
	logic [5:0][63:0] cp_s7;
	logic        dg_s7;
	v3_t         org_s8, ox_s8, oy_s8, oz_s8;
	logic        dg_s8;
	v3_t         org_s9;
	p3_t         pa_s9, pb_s9, pc_s9;
	logic        dg_s9;
	out_item_t   out_s10;

	logic signed [65:0] dsum;
	logic [63:0]        dmag;
	logic [63:0]        dden;
	div_t               dnew;
	div_t               dlast;
	logic [31:0]        snew;

	assign org_in   = {item.origin_z, item.origin_y, item.origin_x};
	assign long_in  = {item.long_z, item.long_y, item.long_x};
	assign plane_in = {item.plane_z, item.plane_y, item.plane_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
			wp_q <= '0;
			wn_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_WEIGHT_LONG:   wl_q <= wr_data;
				REG_WEIGHT_PLANE:  wp_q <= wr_data;
				REG_WEIGHT_NORMAL: wn_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || !point_stall;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign item_stall  = !en[0];
	assign point_valid = vld_q[NST-1];
	assign point       = out_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= item_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: axis differences
	always_ff @(posedge clk) begin
		if (en[0]) begin
			org_s1 <= org_in;
			for (int i = 0; i < 3; i++) begin
				ox_s1[i] <= sat32(72'($signed(long_in[i])) - 72'($signed(org_in[i])));
				oy_s1[i] <= sat32(72'($signed(plane_in[i])) - 72'($signed(org_in[i])));
			end
		end
	end

	// s2: dot product terms
	always_ff @(posedge clk) begin
		if (en[1]) begin
			org_s2 <= org_s1;
			ox_s2  <= ox_s1;
			oy_s2  <= oy_s1;
			for (int i = 0; i < 3; i++) begin
				pxx_s2[i] <= $signed(ox_s1[i]) * $signed(ox_s1[i]);
				pxy_s2[i] <= $signed(ox_s1[i]) * $signed(oy_s1[i]);
			end
		end
	end

	// s3: sums, sign and magnitude, divider setup
	always_comb begin
		dsum = 66'($signed(pxy_s2[0])) + 66'($signed(pxy_s2[1])) + 66'($signed(pxy_s2[2]));
		dden = pxx_s2[0] + pxx_s2[1] + pxx_s2[2];
		dmag = dsum[65] ? 64'(-dsum) : dsum[63:0];
		dnew.org   = org_s2;
		dnew.ox    = ox_s2;
		dnew.oy    = oy_s2;
		dnew.neg   = dsum[65];
		dnew.den   = dden;
		dnew.degen = (dden == 64'd0);
		dnew.rem   = {16'd0, dmag, 16'd0};
		dnew.ovf   = ({16'd0, dmag, 16'd0} >= {dden, 32'd0});
		dnew.q     = '0;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dv_s3 <= dnew;
		end
	end

	generate
		for (genvar j = 0; j < NDIV; j++) begin : g_div
			vp3m_div_step #(.BIT(NDIV - 1 - j)) u_step (
				.clk  (clk),
				.en   (en[3+j]),
				.din  ((j == 0) ? dv_s3 : dvo[(j == 0) ? 0 : j-1]),
				.dout (dvo[j])
			);
		end
	endgenerate

	// s4: signed, saturated ratio
	always_comb begin
		dlast = dvo[NDIV-1];
		if (dlast.degen) begin
			snew = '0;
		end else if (dlast.neg) begin
			snew = (dlast.ovf || (dlast.q[31] && |dlast.q[30:0])) ? 32'h8000_0000 : -dlast.q;
		end else begin
			snew = (dlast.ovf || dlast.q[31]) ? 32'h7fff_ffff : dlast.q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NDIV+3]) begin
			org_s4 <= dlast.org;
			ox_s4  <= dlast.ox;
			oy_s4  <= dlast.oy;
			dg_s4  <= dlast.degen;
			s_s4   <= snew;
		end
	end

	// s5: projection products
	always_ff @(posedge clk) begin
		if (en[NDIV+4]) begin
			org_s5 <= org_s4;
			ox_s5  <= ox_s4;
			oy_s5  <= oy_s4;
			dg_s5  <= dg_s4;
			for (int i = 0; i < 3; i++) begin
				sp_s5[i] <= $signed(s_s4) * $signed(ox_s4[i]);
			end
		end
	end

	// s6: remove projection
	always_ff @(posedge clk) begin
		if (en[NDIV+5]) begin
			org_s6 <= org_s5;
			ox_s6  <= ox_s5;
			dg_s6  <= dg_s5;
			for (int i = 0; i < 3; i++) begin
				oy_s6[i] <= sat32(72'($signed(oy_s5[i])) - 72'($signed(qsat(sp_s5[i]))));
			end
		end
	end

	// s7: cross product terms
	always_ff @(posedge clk) begin
		if (en[NDIV+6]) begin
			org_s7   <= org_s6;
			ox_s7    <= ox_s6;
			oy_s7    <= oy_s6;
			dg_s7    <= dg_s6;
			cp_s7[0] <= $signed(ox_s6[1]) * $signed(oy_s6[2]);
			cp_s7[1] <= $signed(ox_s6[2]) * $signed(oy_s6[1]);
			cp_s7[2] <= $signed(ox_s6[2]) * $signed(oy_s6[0]);
			cp_s7[3] <= $signed(ox_s6[0]) * $signed(oy_s6[2]);
			cp_s7[4] <= $signed(ox_s6[0]) * $signed(oy_s6[1]);
			cp_s7[5] <= $signed(ox_s6[1]) * $signed(oy_s6[0]);
		end
	end

	// s8: normal axis
	always_ff @(posedge clk) begin
		if (en[NDIV+7]) begin
			org_s8 <= org_s7;
			ox_s8  <= ox_s7;
			oy_s8  <= oy_s7;
			dg_s8  <= dg_s7;
			for (int i = 0; i < 3; i++) begin
				oz_s8[i] <= sat32((72'($signed(cp_s7[2*i])) - 72'($signed(cp_s7[2*i+1]))) >>> 16);
			end
		end
	end

	// s9: weight products
	always_ff @(posedge clk) begin
		if (en[NDIV+8]) begin
			org_s9 <= org_s8;
			dg_s9  <= dg_s8;
			for (int i = 0; i < 3; i++) begin
				pa_s9[i] <= $signed(wl_q) * $signed(ox_s8[i]);
				pb_s9[i] <= $signed(wp_q) * $signed(oy_s8[i]);
				pc_s9[i] <= $signed(wn_q) * $signed(oz_s8[i]);
			end
		end
	end

	// s10: final sum
	always_ff @(posedge clk) begin
		if (en[NDIV+9]) begin
			out_s10.point_x    <= sat32(72'($signed(org_s9[0]))
				- 72'($signed(qsat(pa_s9[0]))) - 72'($signed(qsat(pb_s9[0])))
				- 72'($signed(qsat(pc_s9[0]))));
			out_s10.point_y    <= sat32(72'($signed(org_s9[1]))
				- 72'($signed(qsat(pa_s9[1]))) - 72'($signed(qsat(pb_s9[1])))
				- 72'($signed(qsat(pc_s9[1]))));
			out_s10.point_z    <= sat32(72'($signed(org_s9[2]))
				- 72'($signed(qsat(pa_s9[2]))) - 72'($signed(qsat(pb_s9[2])))
				- 72'($signed(qsat(pc_s9[2]))));
			out_s10.degenerate <= dg_s9;
		end
	end

endmodule
